// ===== sv/cua_pkg.sv =====
`timescale 1ns / 1ps
// Shared opcodes, status codes and beat widths for the checked unsigned ALU.
package cua_pkg;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_MOD = 4'd3,
      OP_DIV = 4'd4,
      OP_POW = 4'd5,
      OP_EQ  = 4'd6,
      OP_NE  = 4'd7,
      OP_LT  = 4'd8,
      OP_GT  = 4'd9,
      OP_LE  = 4'd10,
      OP_GE  = 4'd11,
      OP_AND = 4'd12,
      OP_OR  = 4'd13
   } op_type;

   typedef logic [1:0] status_type;

   localparam status_type ST_OK   = 2'd0;
   localparam status_type ST_OVF  = 2'd1;
   localparam status_type ST_DIVZ = 2'd2;

   localparam int FIELD_W = 64;
   localparam int REQ_W   = 136;
   localparam int RSP_W   = 72;

endpackage

// ===== sv/checked_unsigned_alu.sv =====
`timescale 1ns / 1ps
// Checked unsigned ALU: each request passes the stage registers, then the output register;
// at WIDTH = 64 the pipeline length is set by the square-and-multiply chain of the power unit
// (8-bit digit multiply per stage); the divider retires one quotient bit per stage.
// Throughput is one beat per cycle; a stalled output freezes the whole pipeline.
// Synchronous reset clears all valid bits; data registers are not reset.
module checked_unsigned_alu
   import cua_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // op[3:0], lhs[67:4], rhs[131:68], zero pad
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // value[63:0], status[65:64], zero pad
);

   localparam int W    = WIDTH;
   localparam int MW   = 2 * WIDTH;
   localparam int NDIG = (WIDTH + 7) / 8;
   localparam int DGW  = NDIG * 8;
   localparam int EB   = $clog2(WIDTH / 2 + 1);
   localparam int PS   = 2 * EB * NDIG;
   localparam int LD   = (WIDTH > PS) ? WIDTH : PS;
   localparam int LW   = $clog2(WIDTH + 1);
   localparam int MLW  = 2 * LW;

   logic en;

   op_type         e_op;
   logic [W-1:0]   e_a;
   logic [W-1:0]   e_b;
   logic [W:0]     e_sum;
   logic [LW-1:0]  e_len;
   logic           e_fit;
   logic [W-1:0]   e_sv;
   status_type     e_sst;
   logic           e_pdir;

   logic           vld_ff  [LD];
   op_type         op_ff   [LD];
   op_type         op_in   [LD];
   logic [W-1:0]   sv_ff   [LD];
   logic [W-1:0]   sv_in   [LD];
   status_type     sst_ff  [LD];
   status_type     sst_in  [LD];
   logic           pdir_ff [LD];
   logic           pdir_in [LD];

   logic [W-1:0]   rem_ff  [LD];
   logic [W-1:0]   rem_in  [LD];
   logic [W-1:0]   num_ff  [LD];
   logic [W-1:0]   num_in  [LD];
   logic [W-1:0]   dvs_ff  [LD];
   logic [W-1:0]   dvs_in  [LD];
   logic [W-1:0]   quo_ff  [LD];
   logic [W-1:0]   quo_in  [LD];

   logic [W-1:0]   mx_ff   [LD];
   logic [W-1:0]   mx_in   [LD];
   logic [DGW-1:0] my_ff   [LD];
   logic [DGW-1:0] my_in   [LD];
   logic [MW-1:0]  macc_ff [LD];
   logic [MW-1:0]  macc_in [LD];

   logic [W-1:0]   pr_ff   [LD];
   logic [W-1:0]   pr_in   [LD];
   logic [W-1:0]   px_ff   [LD];
   logic [W-1:0]   px_in   [LD];
   logic [W-1:0]   py_ff   [LD];
   logic [W-1:0]   py_in   [LD];
   logic [W-1:0]   pacc_ff [LD];
   logic [W-1:0]   pacc_in [LD];
   logic [W-1:0]   pb_ff   [LD];
   logic [W-1:0]   pb_in   [LD];
   logic [EB-1:0]  pe_ff   [LD];
   logic [EB-1:0]  pe_in   [LD];

   logic             rsp_tvalid_ff;
   logic [RSP_W-1:0] rsp_tdata_ff;
   logic [RSP_W-1:0] rsp_tdata_in;
   logic [W-1:0]     o_v;
   status_type       o_st;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign e_op = op_type'(req_tdata[3:0]);
   assign e_a  = req_tdata[4 +: W];
   assign e_b  = req_tdata[4 + FIELD_W +: W];

   always_comb begin
      e_sum = {1'b0, e_a} + {1'b0, e_b};
      e_len = '0;
      for (int i = 0; i < W; i++) begin
         if (e_a[i]) begin
            e_len = LW'(i + 1);
         end
      end
      e_fit  = (e_b <= W'(W)) && ((MLW'(e_b[LW-1:0]) * MLW'(e_len)) <= MLW'(W));
      e_sv   = '0;
      e_sst  = ST_OK;
      e_pdir = 1'b0;
      case (e_op)
         OP_ADD: begin
            e_sv  = e_sum[W-1:0];
            e_sst = e_sum[W] ? ST_OVF : ST_OK;
         end
         OP_SUB: begin
            e_sv  = e_a - e_b;
            e_sst = (e_b > e_a) ? ST_OVF : ST_OK;
         end
         OP_MOD, OP_DIV: begin
            e_sst = (e_b == '0) ? ST_DIVZ : ST_OK;
         end
         OP_POW: begin
            if (e_a <= W'(1)) begin
               e_sv   = e_a;
               e_pdir = 1'b1;
            end else if (e_b <= W'(1)) begin
               e_sv   = (e_b == '0) ? W'(1) : e_a;
               e_pdir = 1'b1;
            end else if (!e_fit) begin
               e_sst  = ST_OVF;
               e_pdir = 1'b1;
            end
         end
         OP_EQ:   e_sv = W'(e_a == e_b);
         OP_NE:   e_sv = W'(e_a != e_b);
         OP_LT:   e_sv = W'(e_a < e_b);
         OP_GT:   e_sv = W'(e_a > e_b);
         OP_LE:   e_sv = W'(e_a <= e_b);
         OP_GE:   e_sv = W'(e_a >= e_b);
         OP_AND:  e_sv = W'((e_a != '0) && (e_b != '0));
         OP_OR:   e_sv = W'((e_a != '0) || (e_b != '0));
         default: e_sv = '0;
      endcase
   end

   for (genvar K = 0; K < LD; K++) begin : g_stage
      localparam int M  = K / NDIG;
      localparam int J  = K % NDIG;
      localparam int BP = (M / 2 < EB) ? EB - 1 - M / 2 : 0;
      localparam bit SQ = (M % 2) == 0;

      op_type         s_op;
      logic [W-1:0]   s_sv, s_rem, s_num, s_dvs, s_quo, s_mx;
      logic [W-1:0]   s_pr, s_px, s_py, s_pacc, s_pb;
      status_type     s_sst;
      logic           s_pdir;
      logic [DGW-1:0] s_my;
      logic [MW-1:0]  s_macc;
      logic [EB-1:0]  s_pe;

      if (K == 0) begin : g_src_entry
         assign s_op   = e_op;
         assign s_sv   = e_sv;
         assign s_sst  = e_sst;
         assign s_pdir = e_pdir;
         assign s_rem  = '0;
         assign s_num  = e_a;
         assign s_dvs  = e_b;
         assign s_quo  = '0;
         assign s_mx   = e_a;
         assign s_my   = DGW'(e_b);
         assign s_macc = '0;
         assign s_pr   = W'(1);
         assign s_px   = '0;
         assign s_py   = '0;
         assign s_pacc = '0;
         assign s_pb   = e_a;
         assign s_pe   = e_b[EB-1:0];
      end else begin : g_src_reg
         assign s_op   = op_ff[K-1];
         assign s_sv   = sv_ff[K-1];
         assign s_sst  = sst_ff[K-1];
         assign s_pdir = pdir_ff[K-1];
         assign s_rem  = rem_ff[K-1];
         assign s_num  = num_ff[K-1];
         assign s_dvs  = dvs_ff[K-1];
         assign s_quo  = quo_ff[K-1];
         assign s_mx   = mx_ff[K-1];
         assign s_my   = my_ff[K-1];
         assign s_macc = macc_ff[K-1];
         assign s_pr   = pr_ff[K-1];
         assign s_px   = px_ff[K-1];
         assign s_py   = py_ff[K-1];
         assign s_pacc = pacc_ff[K-1];
         assign s_pb   = pb_ff[K-1];
         assign s_pe   = pe_ff[K-1];
      end

      assign op_in[K]   = s_op;
      assign sv_in[K]   = s_sv;
      assign sst_in[K]  = s_sst;
      assign pdir_in[K] = s_pdir;
      assign dvs_in[K]  = s_dvs;
      assign mx_in[K]   = s_mx;
      assign pb_in[K]   = s_pb;
      assign pe_in[K]   = s_pe;

      if (K < W) begin : g_div
         logic [W:0] t;
         logic       ge;
         logic [W:0] diff;
         assign t         = {s_rem, s_num[W-1]};
         assign ge        = t >= {1'b0, s_dvs};
         assign diff      = t - {1'b0, s_dvs};
         assign rem_in[K] = ge ? diff[W-1:0] : t[W-1:0];
         assign num_in[K] = s_num << 1;
         assign quo_in[K] = {s_quo[W-2:0], ge};
      end else begin : g_div_hold
         assign rem_in[K] = s_rem;
         assign num_in[K] = s_num;
         assign quo_in[K] = s_quo;
      end

      if (K < NDIG) begin : g_mul
         logic [MW-1:0] pp;
         assign pp         = MW'(s_mx) * MW'(s_my[7:0]);
         assign macc_in[K] = s_macc + (pp << (8 * J));
         assign my_in[K]   = s_my >> 8;
      end else begin : g_mul_hold
         assign macc_in[K] = s_macc;
         assign my_in[K]   = s_my;
      end

      if (K < PS) begin : g_pow
         logic [W-1:0]  x_use, y_use, a_use;
         logic [MW-1:0] pp, psh;
         logic [W-1:0]  acc_new;
         if (J == 0) begin : g_load
            assign x_use = s_pr;
            assign y_use = SQ ? s_pr : (s_pe[BP] ? s_pb : W'(1));
            assign a_use = '0;
         end else begin : g_cont
            assign x_use = s_px;
            assign y_use = s_py;
            assign a_use = s_pacc;
         end
         assign pp         = MW'(x_use) * MW'(y_use[7:0]);
         assign psh        = pp << (8 * J);
         assign acc_new    = a_use + psh[W-1:0];
         assign pacc_in[K] = acc_new;
         assign px_in[K]   = x_use;
         assign py_in[K]   = y_use >> 8;
         assign pr_in[K]   = (J == NDIG - 1) ? acc_new : s_pr;
      end else begin : g_pow_hold
         assign pacc_in[K] = s_pacc;
         assign px_in[K]   = s_px;
         assign py_in[K]   = s_py;
         assign pr_in[K]   = s_pr;
      end
   end

   always_comb begin
      o_v  = sv_ff[LD-1];
      o_st = sst_ff[LD-1];
      case (op_ff[LD-1])
         OP_MUL: begin
            o_v  = macc_ff[LD-1][W-1:0];
            o_st = (|macc_ff[LD-1][MW-1:W]) ? ST_OVF : ST_OK;
         end
         OP_MOD:  o_v = rem_ff[LD-1];
         OP_DIV:  o_v = quo_ff[LD-1];
         OP_POW:  o_v = pdir_ff[LD-1] ? sv_ff[LD-1] : pr_ff[LD-1];
         default: o_v = sv_ff[LD-1];
      endcase
      if (o_st != ST_OK) begin
         o_v = '0;
      end
      rsp_tdata_in = {(RSP_W - FIELD_W - 2)'(0), o_st, FIELD_W'(o_v)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
         for (int k = 0; k < LD; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         rsp_tvalid_ff <= vld_ff[LD-1];
         vld_ff[0]     <= req_tvalid;
         for (int k = 1; k < LD; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
         for (int k = 0; k < LD; k++) begin
            op_ff[k]   <= op_in[k];
            sv_ff[k]   <= sv_in[k];
            sst_ff[k]  <= sst_in[k];
            pdir_ff[k] <= pdir_in[k];
            rem_ff[k]  <= rem_in[k];
            num_ff[k]  <= num_in[k];
            dvs_ff[k]  <= dvs_in[k];
            quo_ff[k]  <= quo_in[k];
            mx_ff[k]   <= mx_in[k];
            my_ff[k]   <= my_in[k];
            macc_ff[k] <= macc_in[k];
            pr_ff[k]   <= pr_in[k];
            px_ff[k]   <= px_in[k];
            py_ff[k]   <= py_in[k];
            pacc_ff[k] <= pacc_in[k];
            pb_ff[k]   <= pb_in[k];
            pe_ff[k]   <= pe_in[k];
         end
      end
   end

endmodule
